>>> rtl/swm_pkg.sv
// shared types and constants of the sliding window median core
package swm_pkg;

  localparam int CFG_WIDTH          = 7;
  localparam int WINDOW_MAX_DEFAULT = 64;
  localparam int SAMPLE_WIDTH_DEF   = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } swm_state_t;

  typedef struct packed {
    logic cfg_write;
    logic take_sample;
    logic scan_start;
    logic scan_step;
    logic write_last;
    logic out_load;
  } swm_cmd_t;

  typedef struct packed {
    logic produce;
    logic scan_done;
    logic out_free;
  } swm_status_t;

endpackage

>>> rtl/swm_ctrl.sv
// controller state machine of the sliding window median core
module swm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  swm_pkg::swm_status_t status,
  output swm_pkg::swm_cmd_t    cmd
);
  import swm_pkg::*;

  swm_state_t state;
  swm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!cfg_valid && s_tvalid) begin
          state_next = ST_OLD;
        end
      end
      ST_OLD: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = status.produce ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    s_tready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cfg_ready       = 1'b1;
        s_tready        = !cfg_valid;
        cmd.cfg_write   = cfg_valid;
        cmd.take_sample = !cfg_valid && s_tvalid;
      end
      ST_OLD: begin
        cmd.scan_start = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_LAST: begin
        cmd.write_last = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_last_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.write_last |-> $past(cmd.scan_step) && $past(status.scan_done))
    else $error("final write without a finished scan");

  a_out_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.write_last && status.produce |=> state == ST_DONE)
    else $error("result dropped after final write");

endmodule

>>> rtl/swm_datapath.sv
// window ring memory, double-banked sorted memory, merge unit and output register
module swm_datapath #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEFAULT,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  swm_pkg::swm_cmd_t            cmd,
  output swm_pkg::swm_status_t         status,
  input  logic [SAMPLE_WIDTH-1:0]      sample,
  input  logic [swm_pkg::CFG_WIDTH-1:0] cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SAMPLE_WIDTH-1:0]      median
);
  import swm_pkg::*;

  localparam int CW         = $clog2(WINDOW_MAX + 1);
  localparam int AW         = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SORT_DEPTH = 2 ** (AW + 1);
  localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  logic [CFG_WIDTH-1:0]    window_size;
  logic [CW-1:0]           fill_count;
  logic [AW-1:0]           oldest_slot;
  logic                    bank;
  logic [CW-1:0]           rcnt;
  logic [CW-1:0]           wcnt;
  logic                    rd_valid;
  logic                    removed;
  logic [AW-1:0]           slot_q;
  logic [SAMPLE_WIDTH-1:0] carry;
  logic [SAMPLE_WIDTH-1:0] med_code;
  logic [SAMPLE_WIDTH-1:0] win_rdata;
  logic [SAMPLE_WIDTH-1:0] sort_rdata;

  logic [SAMPLE_WIDTH-1:0] win_mem  [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] sort_mem [SORT_DEPTH];

  logic [CW-1:0]           k_eff;
  logic [CW-1:0]           mid;
  logic                    full;
  logic                    produce;
  logic [AW-1:0]           slot;
  logic [AW-1:0]           oldest_next;
  logic                    rd_issue;
  logic                    keep;
  logic                    skip;
  logic [SAMPLE_WIDTH-1:0] lo;
  logic [SAMPLE_WIDTH-1:0] hi;

  always_comb begin
    if (window_size == '0) begin
      k_eff = CW'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      k_eff = CW'(WINDOW_MAX);
    end else begin
      k_eff = CW'(window_size);
    end
  end

  assign mid      = CW'((k_eff - CW'(1)) >> 1);
  assign full     = fill_count >= k_eff;
  assign produce  = full || ((CW + 1)'(fill_count) + (CW + 1)'(1) >= (CW + 1)'(k_eff));
  assign slot     = full ? oldest_slot : fill_count[AW-1:0];
  assign rd_issue = rcnt != fill_count;

  always_comb begin
    if (CW'(oldest_slot) + CW'(1) == k_eff) begin
      oldest_next = '0;
    end else begin
      oldest_next = oldest_slot + AW'(1);
    end
  end

  // merge: drop the leaving sample once, carry the new one through
  assign skip = rd_valid && !removed && (sort_rdata == win_rdata);
  assign keep = rd_valid && !skip;
  assign lo   = (carry < sort_rdata) ? carry : sort_rdata;
  assign hi   = (carry < sort_rdata) ? sort_rdata : carry;

  assign status.produce   = produce;
  assign status.scan_done = !rd_issue && !rd_valid;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_WIDTH'(1);
      fill_count  <= '0;
      oldest_slot <= '0;
      bank        <= 1'b0;
      rcnt        <= '0;
      wcnt        <= '0;
      rd_valid    <= 1'b0;
      removed     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.cfg_write) begin
        window_size <= cfg_data;
        fill_count  <= '0;
        oldest_slot <= '0;
      end
      if (cmd.scan_start) begin
        rcnt     <= '0;
        wcnt     <= '0;
        rd_valid <= 1'b0;
        removed  <= !full;
      end
      if (cmd.scan_step) begin
        rd_valid <= rd_issue;
        if (rd_issue) begin
          rcnt <= rcnt + CW'(1);
        end
        if (skip) begin
          removed <= 1'b1;
        end
        if (keep) begin
          wcnt <= wcnt + CW'(1);
        end
      end
      if (cmd.write_last) begin
        bank <= !bank;
        if (full) begin
          oldest_slot <= oldest_next;
        end else begin
          fill_count <= fill_count + CW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      carry     <= sample ^ SIGN_BIT;
      slot_q    <= slot;
      win_rdata <= win_mem[slot];
    end
    if (cmd.scan_start) begin
      win_mem[slot_q] <= carry;
    end
    if (cmd.scan_step && keep) begin
      carry <= hi;
      if (wcnt == mid) begin
        med_code <= lo;
      end
    end
    if (cmd.write_last && wcnt == mid) begin
      med_code <= carry;
    end
    if (cmd.out_load) begin
      median <= med_code ^ SIGN_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && rd_issue) begin
      sort_rdata <= sort_mem[{bank, rcnt[AW-1:0]}];
    end
    if (cmd.scan_step && keep) begin
      sort_mem[{!bank, wcnt[AW-1:0]}] <= lo;
    end
    if (cmd.write_last) begin
      sort_mem[{!bank, wcnt[AW-1:0]}] <= carry;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= k_eff)
    else $error("fill count beyond window size");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(oldest_slot) < k_eff)
    else $error("oldest slot outside window");

  a_removed_once: assert property (@(posedge clk) disable iff (rst)
    cmd.write_last |-> wcnt == (full ? fill_count - CW'(1) : fill_count))
    else $error("leaving sample not removed exactly once");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("output register overwritten");

endmodule

>>> rtl/sliding_window_median_core.sv
// top level of the sliding window median core
// Running median filter: each input transfer carries one signed sample; once the
// window holds window_size samples, every sample yields one output transfer with the
// lower median (sorted index (window_size-1)/2) of the last window_size samples. A
// window_size of 0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX, and every
// configuration write empties the window. For each sample, the sorted memory of fill
// entries, where fill is the number of samples held (at most the window size), is
// walked one entry per cycle through its single read port while the updated list
// is written to the other bank. A finished result waits in the output register
// while the next sample is taken; the next result is held back until that register
// has been read.
module sliding_window_median_core #(
  parameter  int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEFAULT,
  parameter  int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
  localparam int TDATA_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [TDATA_WIDTH-1:0]        s_tdata,   // sample
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [TDATA_WIDTH-1:0]        m_tdata,   // median
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swm_pkg::CFG_WIDTH-1:0] cfg_data   // window_size
);
  import swm_pkg::*;

  swm_cmd_t                cmd;
  swm_status_t             status;
  logic [SAMPLE_WIDTH-1:0] median;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  swm_datapath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (s_tdata[SAMPLE_WIDTH-1:0]),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .median    (median)
  );

  assign m_tdata = TDATA_WIDTH'(median);

endmodule

>>> test/sliding_window_median_checker.sv
`timescale 1ns / 100ps
// scoreboard that tracks the window contents and checks every median transfer
module sliding_window_median_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // sample
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [31:0]                   m_tdata,   // median
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [swm_pkg::CFG_WIDTH-1:0] cfg_data,  // window_size
  output int                            failures,
  output int                            outstanding
);

  localparam int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEFAULT;

  logic [swm_pkg::CFG_WIDTH-1:0] window_size;
  logic signed [31:0] arrivals[$];
  logic signed [31:0] ascending[$];
  logic signed [31:0] medians_due[$];
  logic signed [31:0] due;
  int errors;

  function automatic int span(input logic [swm_pkg::CFG_WIDTH-1:0] size);
    if (size == 0) return 1;
    if (size > WINDOW_MAX) return WINDOW_MAX;
    return int'(size);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 20) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic take_sample(input logic signed [31:0] value);
    int k;
    int p;
    logic signed [31:0] old;
    k = span(window_size);
    if (arrivals.size() >= k) begin
      old = arrivals.pop_front();
      for (p = 0; p < ascending.size(); p++) begin
        if (ascending[p] == old) begin
          ascending.delete(p);
          break;
        end
      end
    end
    arrivals.push_back(value);
    p = 0;
    while (p < ascending.size() && ascending[p] <= value) p++;
    ascending.insert(p, value);
    if (arrivals.size() >= k) medians_due.push_back(ascending[(k - 1) / 2]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      window_size = 1;
      arrivals.delete();
      ascending.delete();
      medians_due.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (medians_due.size() == 0) begin
          report_mismatch($sformatf("median %0d with none due", $signed(m_tdata)));
        end else begin
          due = medians_due.pop_front();
          if (m_tdata !== due)
            report_mismatch($sformatf("median %0d, expected %0d", $signed(m_tdata), due));
        end
      end
      // a write empties the window
      if (cfg_valid && cfg_ready) begin
        window_size = cfg_data;
        arrivals.delete();
        ascending.delete();
      end
      if (s_tvalid && s_tready) take_sample(s_tdata);
    end
    failures <= errors;
    outstanding <= medians_due.size();
  end

endmodule

>>> test/sliding_window_median_core_tb.sv
`timescale 1ns / 100ps
// testbench top: drives samples and window sizes, gives the verdict
module sliding_window_median_core_tb;

  localparam int DRAIN = 100;
  localparam int LIMIT = 400000;
  localparam int PHASES = 12;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic [31:0]                   s_tdata = '0;
  logic                          m_tready = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [swm_pkg::CFG_WIDTH-1:0] cfg_data = '0;
  wire                           s_tready;
  wire                           m_tvalid;
  wire  [31:0]                   m_tdata;
  wire                           cfg_ready;
  int                            failures;
  int                            outstanding;
  int unsigned                   gap_pct = 0;
  int unsigned                   stall_pct = 0;
  int                            cycles = 0;

  logic [31:0] directed_samples[$] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
    32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0005,
    32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'hffff_ffff, 32'hffff_ffff,
    32'h0000_0000, 32'h0000_0007, 32'hffff_fff9, 32'h8000_0001, 32'h7fff_fffe
  };

  always #4 clk = ~clk;

  sliding_window_median_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sliding_window_median_checker median_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= stall_pct);
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] random_sample();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: return $urandom_range(16, 0) - 8;
      7: return 32'h8000_0000 + $urandom_range(15, 0);
      8: return 32'h7fff_ffff - $urandom_range(15, 0);
      default: return $urandom() >> $urandom_range(31, 0);
    endcase
  endfunction

  function automatic logic [swm_pkg::CFG_WIDTH-1:0] phase_window(input int ph);
    case (ph)
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd127;
      4: return 7'd3;
      5: return 7'd64;
      6: return 7'd5;
      7: return 7'd8;
      8: return 7'd13;
      9: return 7'd4;
      10: return 7'd31;
      default: return 7'($urandom_range(40, 1));
    endcase
  endfunction

  // stop sending, wait for every due median, then let the core settle
  task automatic wait_quiet(input int extra);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_window(input logic [swm_pkg::CFG_WIDTH-1:0] size);
    wait_quiet(DRAIN);
    cfg_data <= size;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [31:0] value);
    while ($urandom_range(99, 0) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= value;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    int ph;
    int n;
    int count;
    logic [swm_pkg::CFG_WIDTH-1:0] size;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // window of one straight out of reset
    for (n = 0; n < 3; n++) send_sample(directed_samples[n]);
    set_window(7'd3);
    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    for (ph = 0; ph < PHASES; ph++) begin
      size = phase_window(ph);
      set_window(size);
      case (idle_mode_t'(ph % 4))
        IDLE_NONE: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        IDLE_SENDER: begin
          gap_pct = 77;
          stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          gap_pct = 0;
          stall_pct = 77;
        end
        default: begin
          gap_pct = 38;
          stall_pct = 38;
        end
      endcase
      count = (size == 0) ? 27 : (size > 64) ? 90 : int'(size) + 26;
      for (n = 0; n < count; n++) begin
        if ((ph == 5 || ph == 9) && n == count / 2) wait_quiet(0);
        send_sample(random_sample());
      end
    end
    wait_quiet(DRAIN);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
